/* hdl/retry_backoff_announce_scheduler_top_defines.svh */
// Assertion macros shared by the scheduler RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef RETRY_BACKOFF_ANNOUNCE_SCHEDULER_TOP_DEFINES_SVH
`define RETRY_BACKOFF_ANNOUNCE_SCHEDULER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define RBAS_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("rbas assertion failed");

// Next-cycle implication, checked out of reset.
`define RBAS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("rbas assertion failed");

`else

`define RBAS_ASSERT_NOW(label, clk_s, rst_s, ante, cons)
`define RBAS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)

`endif

`endif

/* hdl/rbas_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rbas_pkg;

    // configuration register width and shift field width
    localparam int CFG_W   = 32;
    localparam int SHIFT_W = 5;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HB_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BACKOFF_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BACKOFF_CAP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_SHIFT = 2'd3;

    // reset values
    localparam logic [CFG_W-1:0]   RST_HB_INTERVAL = 32'd10000;
    localparam logic [CFG_W-1:0]   RST_BACKOFF_BASE = 32'd1000;
    localparam logic [CFG_W-1:0]   RST_BACKOFF_CAP = 32'd30000;
    localparam logic [SHIFT_W-1:0] RST_MAX_SHIFT = 5'd5;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_DONE    = 3'd1,
        OP_DOWN    = 3'd2,
        OP_UP      = 3'd3,
        OP_REFRESH = 3'd4
    } op_t;

    typedef struct packed {
        logic [CFG_W-1:0]   hb_interval;
        logic [CFG_W-1:0]   backoff_base;
        logic [CFG_W-1:0]   backoff_cap;
        logic [SHIFT_W-1:0] max_shift;
    } cfg_t;

endpackage

`default_nettype wire

/* hdl/rbas_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module rbas_cfg_regs
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [rbas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rbas_pkg::CFG_W-1:0]     cfg_data,
    output rbas_pkg::cfg_t                      cfg
);

    rbas_pkg::cfg_t cfg_reg;
    rbas_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                rbas_pkg::CFG_IDX_HB_INTERVAL:  cfg_next.hb_interval = cfg_data;
                rbas_pkg::CFG_IDX_BACKOFF_BASE: cfg_next.backoff_base = cfg_data;
                rbas_pkg::CFG_IDX_BACKOFF_CAP:  cfg_next.backoff_cap = cfg_data;
                rbas_pkg::CFG_IDX_MAX_SHIFT:
                    cfg_next.max_shift = cfg_data[rbas_pkg::SHIFT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hb_interval  <= rbas_pkg::RST_HB_INTERVAL;
            cfg_reg.backoff_base <= rbas_pkg::RST_BACKOFF_BASE;
            cfg_reg.backoff_cap  <= rbas_pkg::RST_BACKOFF_CAP;
            cfg_reg.max_shift    <= rbas_pkg::RST_MAX_SHIFT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/rbas_backoff.sv */
`timescale 1ns / 1ps
`default_nettype none

// Backoff delay for a failure count: base << min(count-1, max_shift), capped at backoff_cap; zero for a zero count.
module rbas_backoff
#(
    parameter int FAIL_COUNT_WIDTH = 8
)
(
    input  wire logic [FAIL_COUNT_WIDTH-1:0] count,
    input  rbas_pkg::cfg_t                   cfg,
    output logic [rbas_pkg::CFG_W-1:0]       delay
);

    localparam int SH_CMP_W =
        (FAIL_COUNT_WIDTH > rbas_pkg::SHIFT_W) ? FAIL_COUNT_WIDTH : rbas_pkg::SHIFT_W;
    localparam int WIDE_W = 2 * rbas_pkg::CFG_W;

    logic [FAIL_COUNT_WIDTH-1:0]  shift_raw;
    logic [SH_CMP_W-1:0]          raw_x;
    logic [SH_CMP_W-1:0]          max_x;
    logic [rbas_pkg::SHIFT_W-1:0] shift;
    logic [WIDE_W-1:0]            shifted;
    logic                         over_cap;

    always_comb
    begin
        shift_raw = count - FAIL_COUNT_WIDTH'(1);
        raw_x     = SH_CMP_W'(shift_raw);
        max_x     = SH_CMP_W'(cfg.max_shift);
        shift     = (raw_x > max_x) ? cfg.max_shift : raw_x[rbas_pkg::SHIFT_W-1:0];
        shifted   = WIDE_W'(cfg.backoff_base) << shift;
        over_cap  = shifted > WIDE_W'(cfg.backoff_cap);
        if (count == '0)
            delay = '0;
        else if (over_cap)
            delay = cfg.backoff_cap;
        else
            delay = shifted[rbas_pkg::CFG_W-1:0];
    end

endmodule

`default_nettype wire

/* hdl/rbas_core.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "retry_backoff_announce_scheduler_top_defines.svh"

// Scheduler state and its registered update; the res_* outputs are the
// post-update values for the item in the input register.
module rbas_core
#(
    parameter int TIME_WIDTH       = 32,
    parameter int FAIL_COUNT_WIDTH = 8
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        fire,
    input  wire logic [2:0]                  operation,
    input  wire logic [TIME_WIDTH-1:0]       now_ms,
    input  wire logic                        post_ok,
    input  rbas_pkg::cfg_t                   cfg,
    output logic                             res_request,
    output logic                             res_kind,
    output logic                             res_announced,
    output logic [FAIL_COUNT_WIDTH-1:0]      res_failures,
    output logic [TIME_WIDTH-1:0]            res_next_attempt
);

    localparam int WIDE_T = (TIME_WIDTH > rbas_pkg::CFG_W) ? TIME_WIDTH : rbas_pkg::CFG_W;

    logic                        link_up_reg, link_up_next;
    logic                        announced_reg, announced_next;
    logic                        pending_reg, pending_next;
    logic [TIME_WIDTH-1:0]       last_ok_reg, last_ok_next;
    logic [TIME_WIDTH-1:0]       next_att_reg, next_att_next;
    logic [FAIL_COUNT_WIDTH-1:0] fail_reg, fail_next;

    rbas_pkg::op_t               op;
    logic [FAIL_COUNT_WIDTH-1:0] fail_inc;
    logic [rbas_pkg::CFG_W-1:0]  delay;
    logic [rbas_pkg::CFG_W-1:0]  addend;
    logic [WIDE_T-1:0]           sum;
    logic [TIME_WIDTH-1:0]       elapsed;
    logic                        want_announce;
    logic                        want_beat;
    logic                        may_post;

    assign op       = rbas_pkg::op_t'(operation);
    assign fail_inc = (&fail_reg) ? fail_reg : fail_reg + FAIL_COUNT_WIDTH'(1);

    rbas_backoff #(
        .FAIL_COUNT_WIDTH (FAIL_COUNT_WIDTH)
    ) u_backoff (
        .count (fail_inc),
        .cfg   (cfg),
        .delay (delay)
    );

    always_comb
    begin
        // one adder serves both the heartbeat and the backoff target
        addend  = post_ok ? cfg.hb_interval : delay;
        sum     = WIDE_T'(now_ms) + WIDE_T'(addend);
        elapsed = now_ms - last_ok_reg;

        want_announce = !announced_reg;
        want_beat     = announced_reg && (WIDE_T'(elapsed) >= WIDE_T'(cfg.hb_interval));
        may_post      = link_up_reg && !pending_reg && (want_announce || want_beat) &&
                        (now_ms >= next_att_reg);

        link_up_next   = link_up_reg;
        announced_next = announced_reg;
        pending_next   = pending_reg;
        last_ok_next   = last_ok_reg;
        next_att_next  = next_att_reg;
        fail_next      = fail_reg;
        res_request    = 1'b0;
        res_kind       = 1'b0;

        unique case (op)
            rbas_pkg::OP_TICK:
            begin
                if (may_post)
                begin
                    res_request  = 1'b1;
                    res_kind     = announced_reg;
                    pending_next = 1'b1;
                end
            end
            rbas_pkg::OP_DONE:
            begin
                if (pending_reg)
                begin
                    pending_next  = 1'b0;
                    next_att_next = sum[TIME_WIDTH-1:0];
                    if (post_ok)
                    begin
                        announced_next = 1'b1;
                        last_ok_next   = now_ms;
                        fail_next      = '0;
                    end
                    else
                    begin
                        fail_next = fail_inc;
                    end
                end
            end
            rbas_pkg::OP_DOWN:
            begin
                link_up_next   = 1'b0;
                announced_next = 1'b0;
                next_att_next  = '0;
                fail_next      = '0;
                pending_next   = 1'b0;
            end
            rbas_pkg::OP_UP:
            begin
                link_up_next   = 1'b1;
                announced_next = 1'b0;
                next_att_next  = now_ms;
                fail_next      = '0;
            end
            rbas_pkg::OP_REFRESH:
            begin
                announced_next = 1'b0;
                next_att_next  = now_ms;
                fail_next      = '0;
            end
            default:
            begin
                // unused codes leave the state alone
            end
        endcase

        res_announced    = announced_next;
        res_failures     = fail_next;
        res_next_attempt = next_att_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_up_reg   <= 1'b0;
            announced_reg <= 1'b0;
            pending_reg   <= 1'b0;
            last_ok_reg   <= '0;
            next_att_reg  <= '0;
            fail_reg      <= '0;
        end
        else if (fire)
        begin
            link_up_reg   <= link_up_next;
            announced_reg <= announced_next;
            pending_reg   <= pending_next;
            last_ok_reg   <= last_ok_next;
            next_att_reg  <= next_att_next;
            fail_reg      <= fail_next;
        end
    end

    // a post can only be outstanding, or acknowledged, while the link is up
    `RBAS_ASSERT_NOW(a_pend_needs_link, clk, rst_n, pending_reg || announced_reg, link_up_reg)
    // a request is only issued while no post is pending
    `RBAS_ASSERT_NOW(a_req_not_pending, clk, rst_n, fire && res_request, !pending_reg)
    // state only moves on an item
    `RBAS_ASSERT_NEXT(a_state_hold, clk, rst_n, !fire,
                      $stable(pending_reg) && $stable(fail_reg) && $stable(next_att_reg))

endmodule

`default_nettype wire

/* hdl/retry_backoff_announce_scheduler_top.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "retry_backoff_announce_scheduler_top_defines.svh"

// Announce/heartbeat scheduler with exponential retry backoff. Each input
// beat carries an operation (tick, post done, link down, link up, refresh),
// the current millisecond time and, for post done, an ok flag; each input
// beat yields exactly one output beat with the request decision and the
// updated announced flag, failure count and next attempt time. A request
// sets an internal pending flag, so the user must answer every request with
// a post done beat before another one is issued. Throughput is one beat per
// clock while out_stall is low: the whole state update (compare, backoff
// shift and cap, one time add) is combinational between the input register
// and the output register, and that loop through the state registers sets
// the rate. An accepted beat waits in the input register and moves to the
// output register once the output stage is empty or being taken. The input
// register keeps accepting while a finished output beat is stalled, until
// both stages hold data. Configuration is written through
// cfg_write/cfg_index/cfg_data
// (0 heartbeat interval, 1 backoff base, 2 backoff cap, 3 max shift) and
// must only change while no beats are in flight. Time arithmetic wraps at
// TIME_WIDTH bits; the failure count saturates at all ones.
module retry_backoff_announce_scheduler_top
#(
    parameter int TIME_WIDTH       = 32,
    parameter int FAIL_COUNT_WIDTH = 8
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // configuration write port
    input  wire logic                           cfg_write,
    input  wire logic [rbas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rbas_pkg::CFG_W-1:0]     cfg_data,

    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [2:0]                     operation,
    input  wire logic [TIME_WIDTH-1:0]          now_ms,
    input  wire logic                           post_ok,

    // output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                post_request,
    output logic                                post_kind,
    output logic                                announced_flag,
    output logic [FAIL_COUNT_WIDTH-1:0]         failure_count,
    output logic [TIME_WIDTH-1:0]               next_attempt_time
);

    rbas_pkg::cfg_t cfg;

    // input register stage
    logic                  in_vld_reg, in_vld_next;
    logic [2:0]            op_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  ok_reg;

    // output register stage
    logic                        out_vld_reg, out_vld_next;
    logic                        req_reg;
    logic                        kind_reg;
    logic                        ann_reg;
    logic [FAIL_COUNT_WIDTH-1:0] fail_out_reg;
    logic [TIME_WIDTH-1:0]       next_att_out_reg;

    // core results for the beat in the input register
    logic                        res_request;
    logic                        res_kind;
    logic                        res_announced;
    logic [FAIL_COUNT_WIDTH-1:0] res_failures;
    logic [TIME_WIDTH-1:0]       res_next_attempt;

    logic in_take;
    logic out_take;
    logic advance;

    rbas_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // advance: input stage beat is processed and moves to the output stage
    assign out_take = out_vld_reg && !out_stall;
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = 1'b1;
        else if (out_take)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= operation;
            now_reg <= now_ms;
            ok_reg  <= post_ok;
        end
        if (advance)
        begin
            req_reg          <= res_request;
            kind_reg         <= res_kind;
            ann_reg          <= res_announced;
            fail_out_reg     <= res_failures;
            next_att_out_reg <= res_next_attempt;
        end
    end

    rbas_core #(
        .TIME_WIDTH       (TIME_WIDTH),
        .FAIL_COUNT_WIDTH (FAIL_COUNT_WIDTH)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (advance),
        .operation        (op_reg),
        .now_ms           (now_reg),
        .post_ok          (ok_reg),
        .cfg              (cfg),
        .res_request      (res_request),
        .res_kind         (res_kind),
        .res_announced    (res_announced),
        .res_failures     (res_failures),
        .res_next_attempt (res_next_attempt)
    );

    assign out_valid         = out_vld_reg;
    assign post_request      = req_reg;
    assign post_kind         = kind_reg;
    assign announced_flag    = ann_reg;
    assign failure_count     = fail_out_reg;
    assign next_attempt_time = next_att_out_reg;

    // a held input beat is never dropped
    `RBAS_ASSERT_NEXT(a_in_kept, clk, rst_n, in_vld_reg && !advance, in_vld_reg)
    // every processed beat shows up on the output
    `RBAS_ASSERT_NEXT(a_adv_out, clk, rst_n, advance, out_vld_reg)

endmodule

`default_nettype wire
